@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge while reset is released
`define SDRI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sdri assertion failed");

// Check prop at every rising clock edge, reset included
`define SDRI_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("sdri assertion failed");

`endif

@@ design/sdri_pkg.sv @@
// ----------------------------------------------------------------------------
// sdri_pkg
// Types, constants and helpers of the damped-spring recoil integrator.
// ----------------------------------------------------------------------------
package sdri_pkg;

    // Timing constants of the tick
    localparam int SUBSTEP_US  = 2000;
    localparam int MAX_TICK_US = 65535;
    localparam int US_PER_S    = 1000000;
    localparam int TICK_W      = 16;

    // Inertia floor (1e-4 in Q8.24)
    localparam int INERTIA_MIN = 1678;

    // Derived widths of the tick sequencer
    localparam int     DT_MAX  = (MAX_TICK_US < 65535) ? MAX_TICK_US : 65535;
    localparam int     DT_W    = $clog2(DT_MAX + 1);
    localparam int     N_MAX   = (DT_MAX + SUBSTEP_US - 1) / SUBSTEP_US;
    localparam int     N_W     = $clog2(N_MAX + 2);
    localparam longint DEN_MAX = longint'(N_MAX) * longint'(US_PER_S);
    localparam int     DEN_W   = $clog2(DEN_MAX + 1);

    // Width of the velocity and rest increments that a kick applies
    localparam int KICK_ADD_W = 36;

    // Configuration register index
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS,
        CFG_DAMPING,
        CFG_INERTIA,
        CFG_KICK_RATE,
        CFG_PEAK_ANGLE,
        CFG_RESIDUAL,
        CFG_YAW_FRACTION,
        CFG_YAW_BIAS
    } cfg_index_t;

    // Top level sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KICK_A,
        ST_KICK_B,
        ST_KICK_C,
        ST_TICK_N,
        ST_TICK_H,
        ST_SUB,
        ST_WAIT,
        ST_RESULT
    } top_state_t;

    // Axis substep sequencer
    typedef enum logic [3:0] {
        AX_IDLE,
        AX_MUL,
        AX_TORQ,
        AX_LOAD,
        AX_DIV,
        AX_DV,
        AX_VUPD,
        AX_XLD,
        AX_XMUL,
        AX_XUPD
    } axis_state_t;

    // Command from the sequencer to one axis
    typedef struct packed {
        logic                         kick;
        logic                         step;
        logic signed [KICK_ADD_W-1:0] rate_add;
        logic signed [KICK_ADD_W-1:0] rest_add;
    } axis_cmd_t;

    // Status of one axis
    typedef struct packed {
        logic               busy;
        logic signed [31:0] angle;
    } axis_stat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/sdri_axis.sv @@
// ----------------------------------------------------------------------------
// sdri_axis
// One axis of the spring: angle, velocity and rest point, a kick adder and a
// bit-serial substep engine (shift-add multipliers, restoring divider).
// ----------------------------------------------------------------------------
module sdri_axis (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sdri_pkg::axis_cmd_t   cmd,
    input  logic [31:0]           stiffness,
    input  logic [31:0]           damping,
    input  logic [31:0]           inertia,
    input  logic [31:0]           step_len,
    output sdri_pkg::axis_stat_t  stat
);

    sdri_pkg::axis_state_t state_reg, state_next;
    logic [5:0]            cnt_reg;
    logic signed [31:0]    x_reg, v_reg, rest_reg;

    logic [32:0]           dmag_reg;
    logic [31:0]           vmag_reg;
    logic                  dneg_reg, vneg_reg, tneg_reg, cap_reg;
    logic [65:0]           pk_reg;
    logic [64:0]           pc_reg;
    logic signed [51:0]    tsum_reg;
    logic [31:0]           rem_reg;
    logic [54:0]           dq_reg;
    logic [88:0]           pd_reg;
    logic [64:0]           px_reg;

    logic signed [32:0]    diff;
    logic [32:0]           diff_mag;
    logic [31:0]           v_mag;
    logic [33:0]           pk_sum;
    logic [32:0]           pc_sum;
    logic signed [51:0]    tk_pos, tc_pos, tk, tc, tsum;
    logic [51:0]           tmag;
    logic [32:0]           r2, r2_sub;
    logic                  ge;
    logic [55:0]           acc;
    logic [56:0]           pd_sum;
    logic [32:0]           px_sum;
    logic [55:0]           dv;
    logic [30:0]           xd;
    logic signed [31:0]    v_upd, x_upd, v_kick, rest_kick;

    // Operands at substep start
    assign diff     = 33'(x_reg) - 33'(rest_reg);
    assign diff_mag = diff[32] ? -diff : diff;
    assign v_mag    = v_reg[31] ? -v_reg : v_reg;

    // Torque products, one multiplier bit per cycle
    assign pk_sum = pk_reg[65:32] + (pk_reg[0] ? {1'b0, dmag_reg} : 34'd0);
    assign pc_sum = pc_reg[64:32] + (pc_reg[0] ? {1'b0, vmag_reg} : 33'd0);

    // Torque sum; t = -(tk + tc), so t is negative when the sum is positive
    assign tk_pos = 52'(pk_reg[64:16]);
    assign tc_pos = 52'(pc_reg[63:16]);
    assign tk     = dneg_reg ? -tk_pos : tk_pos;
    assign tc     = vneg_reg ? -tc_pos : tc_pos;
    assign tsum   = tk + tc;
    assign tmag   = tsum_reg[51] ? -tsum_reg : tsum_reg;

    // Restoring divide step
    assign r2     = {rem_reg, dq_reg[54]};
    assign ge     = r2 >= {1'b0, inertia};
    assign r2_sub = r2 - {1'b0, inertia};

    // Acceleration, held at 2^55 when the quotient overflows
    assign acc    = cap_reg ? {1'b1, 55'd0} : {1'b0, dq_reg};
    assign pd_sum = pd_reg[88:32] + (pd_reg[0] ? {1'b0, acc} : 57'd0);
    assign px_sum = px_reg[64:32] + (px_reg[0] ? {1'b0, vmag_reg} : 33'd0);

    // State updates
    assign dv    = pd_reg[87:32];
    assign xd    = px_reg[62:32];
    assign v_upd = sdri_pkg::sat32(tneg_reg ? 64'(v_reg) - $signed(64'(dv))
                                            : 64'(v_reg) + $signed(64'(dv)));
    assign x_upd = sdri_pkg::sat32(vneg_reg ? 64'(x_reg) - $signed(64'(xd))
                                            : 64'(x_reg) + $signed(64'(xd)));
    assign v_kick    = sdri_pkg::sat32(64'(v_reg) + 64'($signed(cmd.rate_add)));
    assign rest_kick = sdri_pkg::sat32(64'(rest_reg) + 64'($signed(cmd.rest_add)));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdri_pkg::AX_IDLE: if (cmd.step) state_next = sdri_pkg::AX_MUL;
            sdri_pkg::AX_MUL:  if (cnt_reg == 6'd0) state_next = sdri_pkg::AX_TORQ;
            sdri_pkg::AX_TORQ: state_next = sdri_pkg::AX_LOAD;
            sdri_pkg::AX_LOAD: state_next = sdri_pkg::AX_DIV;
            sdri_pkg::AX_DIV:  if (cnt_reg == 6'd0) state_next = sdri_pkg::AX_DV;
            sdri_pkg::AX_DV:   if (cnt_reg == 6'd0) state_next = sdri_pkg::AX_VUPD;
            sdri_pkg::AX_VUPD: state_next = sdri_pkg::AX_XLD;
            sdri_pkg::AX_XLD:  state_next = sdri_pkg::AX_XMUL;
            sdri_pkg::AX_XMUL: if (cnt_reg == 6'd0) state_next = sdri_pkg::AX_XUPD;
            sdri_pkg::AX_XUPD: state_next = sdri_pkg::AX_IDLE;
            default:           state_next = sdri_pkg::AX_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        stat.busy  = (state_reg != sdri_pkg::AX_IDLE);
        stat.angle = x_reg;
    end

    // Control and axis state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdri_pkg::AX_IDLE;
            cnt_reg   <= 6'd0;
            x_reg     <= '0;
            v_reg     <= '0;
            rest_reg  <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                sdri_pkg::AX_IDLE: begin
                    cnt_reg <= 6'd31;
                    if (cmd.kick) begin
                        v_reg    <= v_kick;
                        rest_reg <= rest_kick;
                    end
                end
                sdri_pkg::AX_MUL, sdri_pkg::AX_DV, sdri_pkg::AX_XMUL: begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
                sdri_pkg::AX_LOAD: cnt_reg <= 6'd54;
                sdri_pkg::AX_DIV: begin
                    cnt_reg <= (cnt_reg == 6'd0) ? 6'd31 : cnt_reg - 6'd1;
                end
                sdri_pkg::AX_VUPD: v_reg <= v_upd;
                sdri_pkg::AX_XLD:  cnt_reg <= 6'd31;
                sdri_pkg::AX_XUPD: x_reg <= x_upd;
                default: ;
            endcase
        end
    end

    // Serial datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            sdri_pkg::AX_IDLE: begin
                dmag_reg <= diff_mag;
                dneg_reg <= diff[32];
                vmag_reg <= v_mag;
                vneg_reg <= v_reg[31];
                pk_reg   <= {34'd0, stiffness};
                pc_reg   <= {33'd0, damping};
            end
            sdri_pkg::AX_MUL: begin
                pk_reg <= {1'b0, pk_sum, pk_reg[31:1]};
                pc_reg <= {1'b0, pc_sum, pc_reg[31:1]};
            end
            sdri_pkg::AX_TORQ: tsum_reg <= tsum;
            sdri_pkg::AX_LOAD: begin
                tneg_reg <= !tsum_reg[51] && (tsum_reg != 52'sd0);
                cap_reg  <= 32'(tmag[50:31]) >= inertia;
                rem_reg  <= 32'(tmag[50:31]);
                dq_reg   <= {tmag[30:0], 24'd0};
            end
            sdri_pkg::AX_DIV: begin
                rem_reg <= ge ? r2_sub[31:0] : r2[31:0];
                dq_reg  <= {dq_reg[53:0], ge};
                pd_reg  <= {57'd0, step_len};
            end
            sdri_pkg::AX_DV: pd_reg <= {1'b0, pd_sum, pd_reg[31:1]};
            sdri_pkg::AX_XLD: begin
                vmag_reg <= v_mag;
                vneg_reg <= v_reg[31];
                px_reg   <= {33'd0, step_len};
            end
            sdri_pkg::AX_XMUL: px_reg <= {1'b0, px_sum, px_reg[31:1]};
            default: ;
        endcase
    end

endmodule

@@ design/spring_damper_recoil_integrator_top.sv @@
// ----------------------------------------------------------------------------
// spring_damper_recoil_integrator_top
// Two-axis damped-spring recoil integrator with kick and tick beats.
// ----------------------------------------------------------------------------
// A beat with s_func high is a kick: it adds the kick velocity and the rest
// shift to both axes and returns nothing. A beat with s_func low is a tick
// of s_tick_us microseconds: it runs N = max(1, ceil(dt/2000)) semi-implicit
// Euler substeps and returns the pitch and yaw change as one m_ beat. A tick
// takes the beat, derives N and then the substep length, then runs the
// substeps, whose time is set by the bit-serial multipliers (three in
// series) and the restoring divider of each axis; pitch and yaw run side by
// side. One beat is worked at a time; a finished result waits in the output
// register while the next beat is taken. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must do so only while the block is
// idle, as the block itself does not enforce it.
module spring_damper_recoil_integrator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic signed [15:0]                s_yaw_random,
    input  logic [sdri_pkg::TICK_W-1:0]       s_tick_us,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_delta_pitch,
    output logic signed [31:0]                m_delta_yaw,
    input  logic                              cfg_wr_en,
    input  logic [sdri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata
);

    localparam int DT_W  = sdri_pkg::DT_W;
    localparam int N_W   = sdri_pkg::N_W;
    localparam int DEN_W = sdri_pkg::DEN_W;
    localparam int KW    = sdri_pkg::KICK_ADD_W;

    sdri_pkg::top_state_t state_reg, state_next;

    // Configuration registers
    logic [31:0]        stiffness_reg, damping_reg, inertia_reg;
    logic [30:0]        kick_rate_reg, peak_angle_reg;
    logic [15:0]        residual_reg;
    logic signed [15:0] yaw_fraction_reg, yaw_bias_reg;

    // Beat and tick sequencer registers
    logic signed [15:0] yaw_random_reg;
    logic [DT_W-1:0]    dt_reg, dtr_reg;
    logic [N_W-1:0]     n_reg, sub_cnt_reg;
    logic [DEN_W-1:0]   den_reg, hrem_reg;
    logic [31:0]        hq_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] p0_reg, y0_reg;
    logic signed [17:0] yf_reg;
    logic [31:0]        shift_reg;
    logic signed [KW-1:0] yr_add_reg, yrest_add_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_pitch_reg, m_yaw_reg;

    sdri_pkg::axis_cmd_t  cmd_p, cmd_y;
    sdri_pkg::axis_stat_t stat_p, stat_y;

    logic [DT_W-1:0]    dt_in;
    logic               more_sub;
    logic [DEN_W:0]     hr2, hr2_sub;
    logic               hge;
    logic signed [31:0] yprod;
    logic [31:0]        ymag;
    logic [15:0]        yq;
    logic signed [17:0] yq_s, yf;
    logic [46:0]        sprod;
    logic [16:0]        yfm;
    logic [47:0]        rprod;
    logic [48:0]        rsprod;
    logic signed [KW-1:0] rate_pos, rest_pos;
    logic               last_sub, axes_idle, out_load;

    // Clamp the tick length
    assign dt_in = (int'(s_tick_us) > sdri_pkg::DT_MAX) ? DT_W'(sdri_pkg::DT_MAX)
                                                        : DT_W'(s_tick_us);
    assign more_sub = int'(dtr_reg) > sdri_pkg::SUBSTEP_US;

    // Substep length divide step: h = (dt * 2^32 + den/2) / den
    assign hr2     = {hrem_reg, hq_reg[31]};
    assign hge     = hr2 >= {1'b0, den_reg};
    assign hr2_sub = hr2 - {1'b0, den_reg};

    // Kick stage A: yaw factor and rest shift
    assign yprod = yaw_fraction_reg * yaw_random_reg;
    assign ymag  = yprod[31] ? -yprod : yprod;
    assign yq    = ymag[30:15];
    assign yq_s  = 18'(yq);
    assign yf    = (yprod[31] ? -yq_s : yq_s) + 18'(yaw_bias_reg);
    assign sprod = peak_angle_reg * residual_reg;

    // Kick stage B: yaw velocity and rest increments
    assign yfm      = yf_reg[17] ? 17'(-yf_reg) : 17'(yf_reg);
    assign rprod    = yfm * kick_rate_reg;
    assign rsprod   = yfm * shift_reg;
    assign rate_pos = KW'(rprod[47:15]);
    assign rest_pos = KW'(rsprod[48:15]);

    assign last_sub  = (N_W'(sub_cnt_reg + 1'b1) == n_reg);
    assign axes_idle = !stat_p.busy && !stat_y.busy;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sdri_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_func ? sdri_pkg::ST_KICK_A : sdri_pkg::ST_TICK_N;
                end
            end
            sdri_pkg::ST_KICK_A: state_next = sdri_pkg::ST_KICK_B;
            sdri_pkg::ST_KICK_B: state_next = sdri_pkg::ST_KICK_C;
            sdri_pkg::ST_KICK_C: state_next = sdri_pkg::ST_IDLE;
            sdri_pkg::ST_TICK_N: if (!more_sub) state_next = sdri_pkg::ST_TICK_H;
            sdri_pkg::ST_TICK_H: if (cnt_reg == 5'd0) state_next = sdri_pkg::ST_SUB;
            sdri_pkg::ST_SUB:    state_next = sdri_pkg::ST_WAIT;
            sdri_pkg::ST_WAIT: begin
                if (axes_idle) begin
                    state_next = last_sub ? sdri_pkg::ST_RESULT : sdri_pkg::ST_SUB;
                end
            end
            sdri_pkg::ST_RESULT: if (out_load) state_next = sdri_pkg::ST_IDLE;
            default:             state_next = sdri_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready  = (state_reg == sdri_pkg::ST_IDLE);
        out_load = (state_reg == sdri_pkg::ST_RESULT) && (!m_valid_reg || m_ready);

        cmd_p.kick     = (state_reg == sdri_pkg::ST_KICK_C);
        cmd_p.step     = (state_reg == sdri_pkg::ST_SUB);
        cmd_p.rate_add = KW'(kick_rate_reg);
        cmd_p.rest_add = KW'(shift_reg);

        cmd_y.kick     = cmd_p.kick;
        cmd_y.step     = cmd_p.step;
        cmd_y.rate_add = yr_add_reg;
        cmd_y.rest_add = yrest_add_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sdri_pkg::ST_IDLE;
            m_valid_reg      <= 1'b0;
            stiffness_reg    <= '0;
            damping_reg      <= '0;
            inertia_reg      <= 32'd16777216;
            kick_rate_reg    <= '0;
            peak_angle_reg   <= '0;
            residual_reg     <= '0;
            yaw_fraction_reg <= '0;
            yaw_bias_reg     <= '0;
        end else begin
            state_reg <= state_next;

            // Hold the result until taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Register writes
            if (cfg_wr_en) begin
                case (sdri_pkg::cfg_index_t'(cfg_index))
                    sdri_pkg::CFG_STIFFNESS: stiffness_reg <= cfg_wdata;
                    sdri_pkg::CFG_DAMPING:   damping_reg   <= cfg_wdata;
                    sdri_pkg::CFG_INERTIA: begin
                        inertia_reg <= (cfg_wdata < 32'(sdri_pkg::INERTIA_MIN))
                                       ? 32'(sdri_pkg::INERTIA_MIN) : cfg_wdata;
                    end
                    sdri_pkg::CFG_KICK_RATE:    kick_rate_reg    <= cfg_wdata[30:0];
                    sdri_pkg::CFG_PEAK_ANGLE:   peak_angle_reg   <= cfg_wdata[30:0];
                    sdri_pkg::CFG_RESIDUAL:     residual_reg     <= cfg_wdata[15:0];
                    sdri_pkg::CFG_YAW_FRACTION: yaw_fraction_reg <= cfg_wdata[15:0];
                    sdri_pkg::CFG_YAW_BIAS:     yaw_bias_reg     <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            sdri_pkg::ST_IDLE: begin
                yaw_random_reg <= s_yaw_random;
                dt_reg         <= dt_in;
                dtr_reg        <= dt_in;
                n_reg          <= N_W'(1);
                den_reg        <= DEN_W'(sdri_pkg::US_PER_S);
                p0_reg         <= stat_p.angle;
                y0_reg         <= stat_y.angle;
            end
            sdri_pkg::ST_KICK_A: begin
                yf_reg    <= yf;
                shift_reg <= sprod[46:15];
            end
            sdri_pkg::ST_KICK_B: begin
                yr_add_reg    <= yf_reg[17] ? -rate_pos : rate_pos;
                yrest_add_reg <= yf_reg[17] ? -rest_pos : rest_pos;
            end
            sdri_pkg::ST_TICK_N: begin
                // Count substeps; then seed the divider
                if (more_sub) begin
                    dtr_reg <= DT_W'(int'(dtr_reg) - sdri_pkg::SUBSTEP_US);
                    n_reg   <= N_W'(n_reg + 1'b1);
                    den_reg <= DEN_W'(den_reg + DEN_W'(sdri_pkg::US_PER_S));
                end else begin
                    hrem_reg <= DEN_W'(dt_reg);
                    hq_reg   <= 32'(den_reg >> 1);
                    cnt_reg  <= 5'd31;
                end
                sub_cnt_reg <= '0;
            end
            sdri_pkg::ST_TICK_H: begin
                hrem_reg <= hge ? hr2_sub[DEN_W-1:0] : hr2[DEN_W-1:0];
                hq_reg   <= {hq_reg[30:0], hge};
                cnt_reg  <= cnt_reg - 5'd1;
            end
            sdri_pkg::ST_WAIT: begin
                if (axes_idle) begin
                    sub_cnt_reg <= N_W'(sub_cnt_reg + 1'b1);
                end
            end
            sdri_pkg::ST_RESULT: begin
                if (out_load) begin
                    m_pitch_reg <= sdri_pkg::sat32(64'(stat_p.angle) - 64'(p0_reg));
                    m_yaw_reg   <= sdri_pkg::sat32(64'(stat_y.angle) - 64'(y0_reg));
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_delta_pitch = m_pitch_reg;
    assign m_delta_yaw   = m_yaw_reg;

    // Pitch axis
    sdri_axis u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_p),
        .stiffness (stiffness_reg),
        .damping   (damping_reg),
        .inertia   (inertia_reg),
        .step_len  (hq_reg),
        .stat      (stat_p)
    );

    // Yaw axis
    sdri_axis u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd_y),
        .stiffness (stiffness_reg),
        .damping   (damping_reg),
        .inertia   (inertia_reg),
        .step_len  (hq_reg),
        .stat      (stat_y)
    );

endmodule

@@ design/sdri_checker.sv @@
// ----------------------------------------------------------------------------
// sdri_checker
// Port-level checks of the recoil integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_delta_pitch,
    input logic [31:0] m_delta_yaw
);

    // Drop any result on reset
    `SDRI_ASSERT_NR(a_reset_clears_out, aclk, !aresetn |=> !m_valid)

    // Hold a stalled result beat
    `SDRI_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_delta_pitch) && $stable(m_delta_yaw))

    // After a beat is taken, s_ready is low in the next cycle
    `SDRI_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // A kick never creates a result
    `SDRI_ASSERT(a_kick_no_result, aclk, aresetn, s_valid && s_ready && s_func && !m_valid |=> !m_valid)

endmodule

bind spring_damper_recoil_integrator_top sdri_checker u_sdri_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_func        (s_func),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_delta_pitch (m_delta_pitch),
    .m_delta_yaw   (m_delta_yaw)
);
